// File: hw/rtl/mcf_pkg.sv
// Shared types and constants of the membrane contact force block.
package mcf_pkg;

  typedef enum logic [1:0] {
    SHAPE_NONE   = 2'd0,
    SHAPE_DUCT   = 2'd1,
    SHAPE_SPHERE = 2'd2,
    SHAPE_SHEET  = 2'd3
  } shape_t;

  typedef enum logic [2:0] {
    REG_SHAPE       = 3'd0,
    REG_LENGTH      = 3'd1,
    REG_FACTOR      = 3'd2,
    REG_ADHESION    = 3'd3,
    REG_REPULSION   = 3'd4
  } cfg_reg_t;

  localparam int SQ_STEPS = 32;
  localparam int DIVW = 64;
  localparam int LANES = 5;
  localparam logic [30:0] FACTOR_RESET = 31'd81920;

endpackage

// File: hw/rtl/membrane_contact_force.sv
// Top level: pipelined membrane contact force, one cell per cycle.
// The block accepts one cell every cycle (busy is low except in reset) and
// returns its result, marked by done, once it has passed the 32-step
// square root pipeline and the FRAC_BITS + 1 step restoring dividers that
// follow it, besides the registers around them. Results cannot be
// held off, so the pipeline never stalls. The configuration port is always
// ready; write it only while no cell is in flight.
module membrane_contact_force
  import mcf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [30:0]        cell_rad,
  output logic               done,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic [31:0]        membrane_distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int DV = FRAC_BITS + 1;
  localparam int ONE_W = FRAC_BITS + 1;
  localparam int NW = FRAC_BITS + 2;
  localparam int REACH_W = 62 - FRAC_BITS;
  localparam int PW = 31 + NW;
  localparam int TOT = 42 + DV;
  localparam logic [ONE_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [2:0]         pos;
    logic               twice_en;
    logic               zero;
    logic [30:0]        rad;
    logic [REACH_W-1:0] reach;
    logic [31:0]        mx;
    logic [31:0]        my;
    logic [31:0]        mz;
  } side_t;

  typedef struct packed {
    logic [2:0]  pos;
    logic        zero;
    logic        twice;
    logic        ad_on;
    logic        rp_on;
    logic [31:0] d;
  } tail_t;

  typedef struct packed {
    logic [2:0]    pos;
    logic          zero;
    logic [31:0]   d;
    logic [NW-1:0] n0;
    logic [NW-1:0] n1;
    logic [NW-1:0] n2;
  } late_t;

  shape_t      membrane_shape;
  logic [30:0] mem_len;
  logic [30:0] interaction_factor;
  logic [30:0] adhesion_strength;
  logic [30:0] repulsion_strength;

  logic [TOT-1:0] vld;
  logic           accept;

  assign busy = rst;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      membrane_shape     <= SHAPE_NONE;
      mem_len            <= '0;
      interaction_factor <= FACTOR_RESET;
      adhesion_strength  <= '0;
      repulsion_strength <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHAPE:     membrane_shape     <= shape_t'(cfg_data[1:0]);
        REG_LENGTH:    mem_len            <= cfg_data[30:0];
        REG_FACTOR:    interaction_factor <= cfg_data[30:0];
        REG_ADHESION:  adhesion_strength  <= cfg_data[30:0];
        REG_REPULSION: repulsion_strength <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOT-2:0], accept};
    end
  end

  logic [31:0] mag_x, mag_y, mag_z;
  logic        use_x, use_y;

  assign mag_x = pos_x[31] ? (~$unsigned(pos_x) + 32'd1) : $unsigned(pos_x);
  assign mag_y = pos_y[31] ? (~$unsigned(pos_y) + 32'd1) : $unsigned(pos_y);
  assign mag_z = pos_z[31] ? (~$unsigned(pos_z) + 32'd1) : $unsigned(pos_z);
  assign use_y = (membrane_shape != SHAPE_SHEET);
  assign use_x = use_y && !((membrane_shape == SHAPE_DUCT) && !pos_x[31]);

  side_t sd_a, sd_a_r, sd_b, sd_c;
  logic [63:0] sqx, sqy, sqz, sum_c;

  always_comb begin
    sd_a_r       = sd_a;
    sd_a_r.reach = REACH_W'((62'(interaction_factor) * 62'(sd_a.rad)) >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    sd_a.pos      <= {!pos_z[31], !pos_y[31], !pos_x[31]};
    sd_a.twice_en <= (membrane_shape == SHAPE_SPHERE) || (membrane_shape == SHAPE_SHEET);
    sd_a.zero     <= (membrane_shape == SHAPE_NONE) || (mem_len == 31'd0);
    sd_a.rad      <= cell_rad;
    sd_a.reach    <= '0;
    sd_a.mx       <= use_x ? mag_x : 32'd0;
    sd_a.my       <= use_y ? mag_y : 32'd0;
    sd_a.mz       <= mag_z;

    sd_b <= sd_a_r;
    sqx  <= 64'(sd_a.mx) * 64'(sd_a.mx);
    sqy  <= 64'(sd_a.my) * 64'(sd_a.my);
    sqz  <= 64'(sd_a.mz) * 64'(sd_a.mz);

    sd_c  <= sd_b;
    sum_c <= sqx + sqy + sqz;
  end

  logic [63:0] sq_n [SQ_STEPS];
  logic [63:0] sq_r [SQ_STEPS];
  logic [63:0] sq_n_next [SQ_STEPS];
  logic [63:0] sq_r_next [SQ_STEPS];
  logic [63:0] sn_src [SQ_STEPS];
  logic [63:0] sr_src [SQ_STEPS];
  side_t       sq_sd [SQ_STEPS];

  assign sn_src[0] = sum_c;
  assign sr_src[0] = '0;
  for (genvar j = 1; j < SQ_STEPS; j++) begin : g_sq_src
    assign sn_src[j] = sq_n[j-1];
    assign sr_src[j] = sq_r[j-1];
  end

  always_comb begin
    logic [63:0] bt;
    for (int j = 0; j < SQ_STEPS; j++) begin
      bt = 64'd1 << (62 - 2 * j);
      if (sn_src[j] >= sr_src[j] + bt) begin
        sq_n_next[j] = sn_src[j] - (sr_src[j] + bt);
        sq_r_next[j] = (sr_src[j] >> 1) + bt;
      end else begin
        sq_n_next[j] = sn_src[j];
        sq_r_next[j] = sr_src[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_sd[0] <= sd_c;
    for (int j = 0; j < SQ_STEPS; j++) begin
      sq_n[j] <= sq_n_next[j];
      sq_r[j] <= sq_r_next[j];
    end
    for (int j = 1; j < SQ_STEPS; j++) begin
      sq_sd[j] <= sq_sd[j-1];
    end
  end

  side_t       sd_d;
  logic [31:0] r_cl, d_d, len_d;

  assign sd_d  = sq_sd[SQ_STEPS-1];
  assign len_d = {1'b0, mem_len};
  assign r_cl  = (sq_r[SQ_STEPS-1][31:0] == 32'd0) ? 32'd1 : sq_r[SQ_STEPS-1][31:0];
  assign d_d   = (len_d > r_cl) ? (len_d - r_cl) : (r_cl - len_d);

  logic [DIVW-1:0]  dv_rem [DV][LANES];
  logic [DIVW-1:0]  dv_dvs [DV][LANES];
  logic [ONE_W-1:0] dv_q   [DV][LANES];
  logic [DIVW-1:0]  dv_rem_next [DV][LANES];
  logic [ONE_W-1:0] dv_q_next   [DV][LANES];
  logic [DIVW-1:0]  dr_src [DV][LANES];
  logic [DIVW-1:0]  dd_src [DV][LANES];
  logic [ONE_W-1:0] dq_src [DV][LANES];
  logic [DIVW-1:0]  in_rem [LANES];
  logic [DIVW-1:0]  in_dvs [LANES];
  tail_t            in_tl;
  tail_t            dv_tl [DV];

  always_ff @(posedge clk) begin
    in_rem[0] <= DIVW'(sd_d.mx) << FRAC_BITS;
    in_rem[1] <= DIVW'(sd_d.my) << FRAC_BITS;
    in_rem[2] <= DIVW'(sd_d.mz) << FRAC_BITS;
    in_rem[3] <= DIVW'(d_d) << FRAC_BITS;
    in_rem[4] <= DIVW'(d_d) << FRAC_BITS;
    in_dvs[0] <= DIVW'(r_cl);
    in_dvs[1] <= DIVW'(r_cl);
    in_dvs[2] <= DIVW'(r_cl);
    in_dvs[3] <= DIVW'(sd_d.reach);
    in_dvs[4] <= DIVW'(sd_d.rad);
    in_tl.pos   <= sd_d.pos;
    in_tl.zero  <= sd_d.zero;
    in_tl.twice <= sd_d.twice_en && (len_d < r_cl);
    in_tl.ad_on <= DIVW'(d_d) < DIVW'(sd_d.reach);
    in_tl.rp_on <= d_d < {1'b0, sd_d.rad};
    in_tl.d     <= d_d;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_dv_src
    assign dr_src[0][l] = in_rem[l];
    assign dd_src[0][l] = in_dvs[l];
    assign dq_src[0][l] = '0;
    for (genvar k = 1; k < DV; k++) begin : g_stage
      assign dr_src[k][l] = dv_rem[k-1][l];
      assign dd_src[k][l] = dv_dvs[k-1][l];
      assign dq_src[k][l] = dv_q[k-1][l];
    end
  end

  always_comb begin
    logic [DIVW-1:0] sh;
    for (int k = 0; k < DV; k++) begin
      for (int l = 0; l < LANES; l++) begin
        sh = dd_src[k][l] << (DV - 1 - k);
        if (dr_src[k][l] >= sh) begin
          dv_rem_next[k][l] = dr_src[k][l] - sh;
          dv_q_next[k][l]   = dq_src[k][l] | (ONE_W'(1) << (DV - 1 - k));
        end else begin
          dv_rem_next[k][l] = dr_src[k][l];
          dv_q_next[k][l]   = dq_src[k][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dv_tl[0] <= in_tl;
    for (int k = 0; k < DV; k++) begin
      for (int l = 0; l < LANES; l++) begin
        dv_rem[k][l] <= dv_rem_next[k][l];
        dv_dvs[k][l] <= dd_src[k][l];
        dv_q[k][l]   <= dv_q_next[k][l];
      end
    end
    for (int k = 1; k < DV; k++) begin
      dv_tl[k] <= dv_tl[k-1];
    end
  end

  tail_t            tl_q;
  late_t            lt_e, lt_f, lt_g, lt_h;
  logic [ONE_W-1:0] ta_e, tr_e;
  logic [NW-1:0]    tta_f, ttr_f;
  logic [30:0]      ap_g, pp_g;
  logic             cneg_h;
  logic [30:0]      cmag_h;
  logic signed [31:0] c_h;
  logic [PW-1:0]    pr0_i, pr1_i, pr2_i;
  logic [2:0]       neg_i;
  logic             zero_i;
  logic [31:0]      d_i;

  assign tl_q = dv_tl[DV-1];
  assign c_h  = $signed({1'b0, pp_g}) - $signed({1'b0, ap_g});

  function automatic logic [NW-1:0] dbl(input logic tw, input logic [ONE_W-1:0] q);
    return tw ? {q, 1'b0} : {1'b0, q};
  endfunction

  function automatic logic [31:0] sat(input logic neg, input logic [PW-1:0] m);
    logic [PW-1:0] nm;
    nm = ~m + PW'(1);
    if (neg) begin
      return (m > PW'(33'h080000000)) ? 32'h80000000 : nm[31:0];
    end
    return (m > PW'(32'h7fffffff)) ? 32'h7fffffff : m[31:0];
  endfunction

  always_ff @(posedge clk) begin
    lt_e.pos  <= tl_q.pos;
    lt_e.zero <= tl_q.zero;
    lt_e.d    <= tl_q.d;
    lt_e.n0   <= dbl(tl_q.twice, dv_q[DV-1][0]);
    lt_e.n1   <= dbl(tl_q.twice, dv_q[DV-1][1]);
    lt_e.n2   <= dbl(tl_q.twice, dv_q[DV-1][2]);
    ta_e      <= tl_q.ad_on ? (ONE - dv_q[DV-1][3]) : '0;
    tr_e      <= tl_q.rp_on ? (ONE - dv_q[DV-1][4]) : '0;

    lt_f  <= lt_e;
    tta_f <= NW'(((2 * ONE_W)'(ta_e) * (2 * ONE_W)'(ta_e)) >> FRAC_BITS);
    ttr_f <= NW'(((2 * ONE_W)'(tr_e) * (2 * ONE_W)'(tr_e)) >> FRAC_BITS);

    lt_g <= lt_f;
    ap_g <= 31'(((NW + 31)'(tta_f) * (NW + 31)'(adhesion_strength)) >> FRAC_BITS);
    pp_g <= 31'(((NW + 31)'(ttr_f) * (NW + 31)'(repulsion_strength)) >> FRAC_BITS);

    lt_h   <= lt_g;
    cneg_h <= c_h[31];
    cmag_h <= c_h[31] ? 31'(-c_h) : c_h[30:0];

    pr0_i  <= (PW'(cmag_h) * PW'(lt_h.n0)) >> FRAC_BITS;
    pr1_i  <= (PW'(cmag_h) * PW'(lt_h.n1)) >> FRAC_BITS;
    pr2_i  <= (PW'(cmag_h) * PW'(lt_h.n2)) >> FRAC_BITS;
    neg_i  <= {3{cneg_h}} ^ lt_h.pos;
    zero_i <= lt_h.zero;
    d_i    <= lt_h.d;

    force_x           <= zero_i ? 32'sd0 : $signed(sat(neg_i[0], pr0_i));
    force_y           <= zero_i ? 32'sd0 : $signed(sat(neg_i[1], pr1_i));
    force_z           <= zero_i ? 32'sd0 : $signed(sat(neg_i[2], pr2_i));
    membrane_distance <= zero_i ? 32'd0 : d_i;
  end

  assign done = vld[TOT-1];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, TOT))
    else $error("result strobe out of step with accepted items");

  a_normal_bound: assert property (@(posedge clk) disable iff (rst)
    vld[35+DV] |-> (dv_q[DV-1][0] <= ONE) && (dv_q[DV-1][1] <= ONE) &&
                   (dv_q[DV-1][2] <= ONE))
    else $error("normal component exceeds one");

  a_falloff_bound: assert property (@(posedge clk) disable iff (rst)
    vld[35+DV] && dv_tl[DV-1].ad_on |-> dv_q[DV-1][3] < ONE)
    else $error("adhesion ratio reached one inside the reach");
`endif

endmodule
